// ===== src/cdad_pkg.sv =====
// Shared types, constants and month-length lookup for the date-advance block.
package cdad_pkg;

  // Request beat: start date and the number of days to advance.
  typedef struct packed {
    logic [4:0]  start_day;
    logic [3:0]  start_month;
    logic [13:0] start_year;
    logic [15:0] days_to_add;
  } req_t;

  // Response beat: the resulting date.
  typedef struct packed {
    logic [4:0]  due_day;
    logic [3:0]  due_month;
    logic [13:0] due_year;
  } rsp_t;

  // Working date, with the year's remainder modulo the leap period.
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [13:0] year_rem;
  } date_t;

  localparam int unsigned LeapPeriod = 400;
  localparam int unsigned Century    = 100;
  localparam int unsigned FebLeapLen = 29;
  localparam int unsigned LastMonth  = 12;
  // Shifts of the leap period that fit in the year width: 400 * 32 = 12800.
  localparam int unsigned RemSteps   = 6;

  localparam logic [4:0] MonthLen [13] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Length of a month; months outside one to twelve count as 31 days.
  function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    if (month < 4'd1 || month > 4'(LastMonth)) begin
      len = 5'd31;
    end else if (month == 4'd2 && leap) begin
      len = 5'(FebLeapLen);
    end else begin
      len = MonthLen[month];
    end
    return len;
  endfunction

endpackage

// ===== src/calendar_date_add_days.sv =====
// Top level of the Gregorian date-advance block.
//
// A request beat (req_valid/req_ready) carries a start date and a day count;
// one response beat (rsp_valid/rsp_ready) carries the date that many days
// later. The block handles one request at a time: req_ready is high only
// while it is idle.
// After a request is taken, the year is reduced modulo 400 by a shared
// compare-and-subtract unit, then the day-advance unit steps the date one
// day per cycle. The response becomes valid once the day count is used up.
// The response stays valid and unchanged while the receiver stalls; no new
// request is taken until it is delivered.
// Synchronous reset returns the sequencer to idle with no response pending.
module calendar_date_add_days (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  cdad_pkg::req_t   req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output cdad_pkg::rsp_t   rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_REM,
    S_RUN,
    S_DONE
  } state_t;

  state_t          state;
  logic [2:0]      step;
  logic [15:0]     remaining_days;
  cdad_pkg::date_t cur;
  cdad_pkg::date_t nxt;
  logic [13:0]     divisor;
  logic [13:0]     rem_sub;

  cdad_next_day u_next_day (
    .cur (cur),
    .nxt (nxt)
  );

  // Shared compare-and-subtract: one restoring step of the modulo-400 reduction.
  always_comb begin
    divisor = 14'(cdad_pkg::LeapPeriod) << step;
    rem_sub = cur.year_rem - divisor;
  end

  // Sequencer, working date and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      step           <= '0;
      cur            <= '0;
      remaining_days <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur.day        <= req.start_day;
            cur.month      <= req.start_month;
            cur.year       <= req.start_year;
            cur.year_rem   <= req.start_year;
            remaining_days <= req.days_to_add;
            step           <= 3'(cdad_pkg::RemSteps - 1);
            state          <= S_REM;
          end
        end
        S_REM: begin
          if (cur.year_rem >= divisor) begin
            cur.year_rem <= rem_sub;
          end
          if (step == 3'd0) begin
            state <= S_RUN;
          end else begin
            step <= step - 3'd1;
          end
        end
        S_RUN: begin
          if (remaining_days == 16'd0) begin
            state <= S_DONE;
          end else begin
            cur            <= nxt;
            remaining_days <= remaining_days - 16'd1;
          end
        end
        S_DONE: begin
          if (rsp_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Handshake and response payload.
  always_comb begin
    req_ready     = (state == S_IDLE);
    rsp_valid     = (state == S_DONE);
    rsp.due_day   = cur.day;
    rsp.due_month = cur.month;
    rsp.due_year  = cur.year;
  end

endmodule

// ===== src/cdad_next_day.sv =====
// Advances a working date by one day, tracking the year modulo 400.
module cdad_next_day (
  input  cdad_pkg::date_t cur,
  output cdad_pkg::date_t nxt
);

  logic        leap;
  logic [5:0]  day_inc;
  logic [4:0]  month_inc;
  logic [4:0]  len;

  // Leap year from the low year bits and the remainder modulo 400.
  always_comb begin
    leap = ((cur.year[1:0] == 2'b00) &&
            !(cur.year_rem == 14'(cdad_pkg::Century) ||
              cur.year_rem == 14'(2 * cdad_pkg::Century) ||
              cur.year_rem == 14'(3 * cdad_pkg::Century))) ||
           (cur.year_rem == 14'd0);
  end

  // Day, month and year rollover.
  always_comb begin
    len       = cdad_pkg::days_in(cur.month, leap);
    day_inc   = {1'b0, cur.day} + 6'd1;
    month_inc = {1'b0, cur.month} + 5'd1;
    nxt       = cur;
    if (day_inc > {1'b0, len}) begin
      nxt.day = 5'd1;
      if (month_inc > 5'(cdad_pkg::LastMonth)) begin
        nxt.month = 4'd1;
        nxt.year  = cur.year + 14'd1;
        // The remainder returns to zero when the year reaches a multiple of 400, or when the year wraps to zero.
        if (cur.year == '1 || cur.year_rem == 14'(cdad_pkg::LeapPeriod - 1)) begin
          nxt.year_rem = 14'd0;
        end else begin
          nxt.year_rem = cur.year_rem + 14'd1;
        end
      end else begin
        nxt.month = month_inc[3:0];
      end
    end else begin
      nxt.day = day_inc[4:0];
    end
  end

endmodule
